// File: hw/rtl/blmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blmc_pkg;

    // LED modes
    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_STEADY = 2'd1,
        MODE_FADE   = 2'd2,
        MODE_BLINK  = 2'd3
    } t_mode;

    // Default parameter values
    localparam int DUTY_BITS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF  = 2'd3;

    // Register widths and reset values
    localparam int TICKS_W = 16;
    localparam int STEP_W  = 7;

    localparam logic [TICKS_W-1:0] LONG_PRESS_RST  = 16'd250;
    localparam logic [STEP_W-1:0]  FADE_STEP_RST   = 7'd2;
    localparam logic [TICKS_W-1:0] FADE_PERIOD_RST = 16'd20;
    localparam logic [TICKS_W-1:0] BLINK_HALF_RST  = 16'd100;

    // Stream payload widths
    localparam int DUTY_OUT_W  = 8;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 16;

    // Button handling status handed to the LED engine
    typedef struct packed {
        t_mode mode;
        logic  long_flag;
    } t_press_stat;

endpackage

`default_nettype wire

// File: hw/rtl/blmc_press.sv
`timescale 1ns / 1ps
`default_nettype none

module blmc_press
    import blmc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_button,
    input  wire logic [TICKS_W-1:0] i_long_press_ticks,
    output t_press_stat             o_stat
);

    localparam int CMP_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    t_mode                 r_mode, n_mode;
    logic                  r_held, n_held;
    logic                  r_fired, n_fired;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;

    // Track press, hold and release; step the mode
    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_fired = r_fired;
        n_cnt   = r_cnt;
        if (i_button) begin
            if (!r_held) begin
                n_held  = 1'b1;
                n_fired = 1'b0;
                n_cnt   = '0;
            end else begin
                if (r_cnt != CNT_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (!r_fired && (CMP_W'(n_cnt) >= CMP_W'(i_long_press_ticks))) begin
                    n_fired = 1'b1;
                    case (r_mode)
                        MODE_STEADY: n_mode = MODE_FADE;
                        MODE_FADE:   n_mode = MODE_BLINK;
                        MODE_BLINK:  n_mode = MODE_STEADY;
                        default:     n_mode = r_mode;
                    endcase
                end
            end
        end else if (r_held) begin
            n_held = 1'b0;
            if (!r_fired) begin
                n_mode = (r_mode != MODE_OFF) ? MODE_OFF : MODE_STEADY;
            end
        end
        o_stat.mode      = n_mode;
        o_stat.long_flag = n_held && n_fired;
    end

    // Commit on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_held  <= 1'b0;
            r_fired <= 1'b0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_fired <= n_fired;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/button_led_mode_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Button LED mode controller. Each input word is one millisecond tick carrying
// the sampled button level in bit 0; each tick yields one output word with the
// LED mode, the 8-bit PWM duty and the long-press flag. A short press turns an
// unlit LED steady and a lit one off; a long press cycles steady, fade and
// blink. The block takes one tick per clock cycle: all state updates in a
// single pass into the output register, which a stall on the output side
// holds while the next word is still taken if that register is being drained.
// Output valid is registered and rises in the cycle after input accept. The
// user must write configuration registers through the plain write port only
// while the stream is idle; the block itself does not enforce this.

module button_led_mode_controller_top
    import blmc_pkg::*;
#(
    parameter int DUTY_BITS  = DUTY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [0] button_level
    // output stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata   // [1:0] led_mode, [9:2] duty,
                                                       // [10] long_press_flag
);

    localparam logic [DUTY_BITS-1:0]  LEVEL_MAX  = '1;
    localparam logic [DUTY_BITS-1:0]  LEVEL_INIT = DUTY_BITS'(1) << (DUTY_BITS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;
    localparam int CMP_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;

    // Configuration registers
    logic [TICKS_W-1:0] r_long_press_ticks;
    logic [STEP_W-1:0]  r_fade_step;
    logic [TICKS_W-1:0] r_fade_period;
    logic [TICKS_W-1:0] r_blink_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= LONG_PRESS_RST;
            r_fade_step        <= FADE_STEP_RST;
            r_fade_period      <= FADE_PERIOD_RST;
            r_blink_half       <= BLINK_HALF_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_LONG_PRESS:  r_long_press_ticks <= i_cfg_wdata[TICKS_W-1:0];
                REG_FADE_STEP:   r_fade_step        <= i_cfg_wdata[STEP_W-1:0];
                REG_FADE_PERIOD: r_fade_period      <= i_cfg_wdata[TICKS_W-1:0];
                REG_BLINK_HALF:  r_blink_half       <= i_cfg_wdata[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: take a word whenever the output register is free or draining
    logic r_out_valid;
    logic in_accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Button handling
    t_press_stat press_stat;

    blmc_press #(
        .COUNT_BITS (COUNT_BITS)
    ) u_press (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_accept),
        .i_button           (s_axis_tdata[0]),
        .i_long_press_ticks (r_long_press_ticks),
        .o_stat             (press_stat)
    );

    // LED engine state
    logic [DUTY_BITS-1:0]  r_level, n_level;
    logic                  r_fading_down, n_fading_down;
    logic [COUNT_BITS-1:0] r_fade_cnt, n_fade_cnt;
    logic [COUNT_BITS-1:0] r_blink_cnt, n_blink_cnt;
    logic                  r_blink_on, n_blink_on;
    logic [DUTY_BITS-1:0]  n_duty;

    logic [DUTY_BITS:0]    fade_sum;
    logic [DUTY_BITS-1:0]  fade_level;
    logic [COUNT_BITS-1:0] fade_inc;
    logic [COUNT_BITS-1:0] blink_inc;

    // Compute duty and advance fade or blink timing
    always_comb begin
        n_level       = r_level;
        n_fading_down = r_fading_down;
        n_fade_cnt    = r_fade_cnt;
        n_blink_cnt   = r_blink_cnt;
        n_blink_on    = r_blink_on;
        n_duty        = '0;

        fade_inc  = (r_fade_cnt != CNT_MAX) ? r_fade_cnt + 1'b1 : r_fade_cnt;
        blink_inc = (r_blink_cnt != CNT_MAX) ? r_blink_cnt + 1'b1 : r_blink_cnt;

        // saturating step in the current direction
        fade_sum = {1'b0, r_level} + (DUTY_BITS + 1)'(r_fade_step);
        if (r_fading_down) begin
            fade_level = (r_level > DUTY_BITS'(r_fade_step))
                       ? r_level - DUTY_BITS'(r_fade_step) : '0;
        end else begin
            fade_level = fade_sum[DUTY_BITS] ? LEVEL_MAX : fade_sum[DUTY_BITS-1:0];
        end

        case (press_stat.mode)
            MODE_STEADY: begin
                n_duty = r_level;
            end
            MODE_FADE: begin
                n_fade_cnt = fade_inc;
                if (CMP_W'(fade_inc) >= CMP_W'(r_fade_period)) begin
                    n_fade_cnt = '0;
                    n_level    = fade_level;
                    if (fade_level == '0 || fade_level == LEVEL_MAX) begin
                        n_fading_down = !r_fading_down;
                    end
                end
                n_duty = n_level;
            end
            MODE_BLINK: begin
                n_duty      = r_blink_on ? r_level : '0;
                n_blink_cnt = blink_inc;
                if (CMP_W'(blink_inc) >= CMP_W'(r_blink_half)) begin
                    n_blink_cnt = '0;
                    n_blink_on  = !r_blink_on;
                end
            end
            default: begin
                n_duty = '0;
            end
        endcase
    end

    // Commit engine state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level       <= LEVEL_INIT;
            r_fading_down <= 1'b0;
            r_fade_cnt    <= '0;
            r_blink_cnt   <= '0;
            r_blink_on    <= 1'b1;
        end else if (in_accept) begin
            r_level       <= n_level;
            r_fading_down <= n_fading_down;
            r_fade_cnt    <= n_fade_cnt;
            r_blink_cnt   <= n_blink_cnt;
            r_blink_on    <= n_blink_on;
        end
    end

    // Output register
    t_mode                 r_out_mode;
    logic [DUTY_OUT_W-1:0] r_out_duty;
    logic                  r_out_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_mode <= press_stat.mode;
            r_out_duty <= n_duty[DUTY_OUT_W-1:0];
            r_out_flag <= press_stat.long_flag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_flag, r_out_duty, r_out_mode};

endmodule

`default_nettype wire
